// ----- rtl/core/htr_pkg.sv -----
// Shared types for the humidity/temperature sensor readout sequencer.
`default_nettype none

package htr_pkg;

	typedef enum logic [2:0] {
		OP_START,
		OP_WRITE,
		OP_READ_ACK,
		OP_READ_NACK,
		OP_STOP,
		OP_WAIT,
		OP_REPORT
	} bus_op_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_ADDR_NACK,
		ST_CMD_NACK,
		ST_TIMEOUT,
		ST_CRC_ERR
	} status_t;

	typedef struct packed {
		bus_op_t            bus_op;
		logic [7:0]         bus_byte;
		logic [15:0]        wait_time;
		status_t            status;
		logic signed [11:0] value;
		logic               last;
	} res_t;

	typedef struct packed {
		logic [6:0]  device_address;
		logic [7:0]  temp_command;
		logic [7:0]  humid_command;
		logic [7:0]  poll_limit;
		logic [15:0] wait_micros;
	} cfg_t;

	typedef struct packed {
		logic ld_hi;
		logic ld_lo;
	} conv_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/htr_cfg.sv -----
// APB configuration registers of the sensor readout sequencer.
`default_nettype none

module htr_cfg import htr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	typedef enum logic [2:0] {
		REG_DEV_ADDR,
		REG_TEMP_CMD,
		REG_HUMID_CMD,
		REG_POLL_LIMIT,
		REG_WAIT_MICROS
	} reg_idx_t;

	logic [2:0] idx;
	logic       wr;
	cfg_t       cfg_q;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= 7'd64;
			cfg_q.temp_command   <= 8'd243;
			cfg_q.humid_command  <= 8'd245;
			cfg_q.poll_limit     <= 8'd255;
			cfg_q.wait_micros    <= 16'd1000;
		end else if (wr) begin
			case (idx)
				REG_DEV_ADDR:    cfg_q.device_address <= pwdata[6:0];
				REG_TEMP_CMD:    cfg_q.temp_command   <= pwdata[7:0];
				REG_HUMID_CMD:   cfg_q.humid_command  <= pwdata[7:0];
				REG_POLL_LIMIT:  cfg_q.poll_limit     <= pwdata[7:0];
				REG_WAIT_MICROS: cfg_q.wait_micros    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_DEV_ADDR:    prdata = {25'd0, cfg_q.device_address};
			REG_TEMP_CMD:    prdata = {24'd0, cfg_q.temp_command};
			REG_HUMID_CMD:   prdata = {24'd0, cfg_q.humid_command};
			REG_POLL_LIMIT:  prdata = {24'd0, cfg_q.poll_limit};
			REG_WAIT_MICROS: prdata = {16'd0, cfg_q.wait_micros};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/htr_conv.sv -----
// Data byte capture, CRC-8 check value and fixed-point conversion.
`default_nettype none

module htr_conv import htr_pkg::*; (
	input  wire logic               clk,
	input  conv_ctl_t               ctl,
	input  wire logic [7:0]         data,
	input  wire logic               kind,
	output logic      [7:0]         crc,
	output logic signed [11:0]      value
);

	localparam logic [7:0]         CRC_POLY   = 8'h31;
	localparam logic [30:0]        TEMP_SCALE = 31'd17572;
	localparam logic signed [31:0] TEMP_OFS   = 32'sd307036160;
	localparam logic [22:0]        HUM_SCALE  = 23'd125;
	localparam logic signed [11:0] HUM_OFS    = 12'sd6;
	localparam logic [29:0]        RECIP_TEN  = 30'd52429;

	function automatic logic [7:0] crc8(input logic [7:0] crc_in, input logic [7:0] b);
		logic [7:0] c;
		c = crc_in ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	logic [7:0]         hi_q;
	logic [7:0]         crc_hi_q;
	logic [7:0]         crc_q;
	logic [30:0]        prod_q;
	logic [6:0]         hum_q;
	logic [15:0]        raw;
	logic [22:0]        hum_prod;
	logic signed [31:0] num;
	logic               neg;
	logic [29:0]        mag;
	logic [13:0]        whole;
	logic [29:0]        q_prod;
	logic signed [11:0] t_abs;
	logic signed [11:0] t_val;
	logic signed [11:0] h_val;

	assign raw      = {hi_q, data};
	assign hum_prod = 23'(raw) * HUM_SCALE;

	always_ff @(posedge clk) begin
		if (ctl.ld_hi) begin
			hi_q     <= data;
			crc_hi_q <= crc8(8'h00, data);
		end
		if (ctl.ld_lo) begin
			crc_q  <= crc8(crc_hi_q, data);
			prod_q <= 31'(31'(raw) * TEMP_SCALE);
			hum_q  <= hum_prod[22:16];
		end
	end

	// truncate toward zero: floor on the magnitude, then restore the sign
	assign num    = $signed({1'b0, prod_q}) - TEMP_OFS;
	assign neg    = num[31];
	assign mag    = neg ? 30'(-num) : num[29:0];
	assign whole  = mag[29:16];
	assign q_prod = 30'(whole) * RECIP_TEN;
	assign t_abs  = $signed({1'b0, q_prod[29:19]});
	assign t_val  = neg ? -t_abs : t_abs;
	assign h_val  = $signed({5'd0, hum_q}) - HUM_OFS;

	assign crc   = crc_q;
	assign value = kind ? h_val : t_val;

endmodule

`default_nettype wire

// ----- rtl/core/htr_outq.sv -----
// Two-entry result buffer feeding the result channel.
`default_nettype none

module htr_outq import htr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire logic [1:0] load_cnt,
	input  res_t            r0,
	input  res_t            r1,
	input  wire logic       res_stall,
	output logic            res_valid,
	output res_t            res,
	output logic            free
);

	logic [1:0] cnt_q;
	res_t       slot0_q;
	res_t       slot1_q;
	logic       take;

	assign res_valid = cnt_q != 2'd0;
	assign res       = slot0_q;
	assign take      = res_valid && !res_stall;
	assign free      = (cnt_q == 2'd0) || (cnt_q == 2'd1 && take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= load_cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= r0;
			slot1_q <= r1;
		end else if (take) begin
			slot0_q <= slot1_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("result count out of range");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free) else $error("results loaded over pending transaction");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall && !load |=> $stable(slot0_q))
		else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/htr_seq.sv -----
// Input register and measurement sequence state machine.
`default_nettype none

module htr_seq import htr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire logic [1:0]  action,
	input  wire logic        kind,
	input  wire logic        acked,
	input  wire logic [7:0]  read_byte,
	input  cfg_t             cfg,
	input  wire logic        free,
	input  wire logic [7:0]  crc,
	input  wire logic signed [11:0] conv_value,
	output conv_ctl_t        conv_ctl,
	output logic [7:0]       conv_data,
	output logic             conv_kind,
	output logic             load,
	output logic [1:0]       load_cnt,
	output res_t             r0,
	output res_t             r1
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ADDR_ACK,
		PH_CMD_ACK,
		PH_DELAY,
		PH_POLL_ACK,
		PH_READ
	} phase_t;

	typedef enum logic [1:0] {
		ACT_START,
		ACT_ACK,
		ACT_READ,
		ACT_WAIT_DONE
	} action_t;

	function automatic res_t mk(input bus_op_t op, input logic [7:0] b, input logic [15:0] wt,
			input status_t st, input logic signed [11:0] v, input logic lst);
		res_t r;
		r.bus_op    = op;
		r.bus_byte  = b;
		r.wait_time = wt;
		r.status    = st;
		r.value     = v;
		r.last      = lst;
		return r;
	endfunction

	phase_t     phase_q, phase_d;
	logic       kind_q, kind_d;
	logic [7:0] attempts_q, attempts_d;
	logic [1:0] idx_q, idx_d;

	logic       valid_s1;
	action_t    action_s1;
	logic       kind_s1;
	logic       acked_s1;
	logic [7:0] byte_s1;

	logic       proc;
	logic [7:0] addr_w;
	logic [7:0] addr_r;

	assign proc      = valid_s1 && free;
	assign cmd_stall = valid_s1 && !proc;
	assign load      = proc;
	assign addr_w    = {cfg.device_address, 1'b0};
	assign addr_r    = {cfg.device_address, 1'b1};
	assign conv_data = byte_s1;
	assign conv_kind = kind_q;

	always_comb begin
		phase_d    = phase_q;
		kind_d     = kind_q;
		attempts_d = attempts_q;
		idx_d      = idx_q;
		load_cnt   = 2'd0;
		conv_ctl   = '0;
		r0         = mk(OP_STOP, 8'd0, 16'd0, ST_OK, 12'sd0, 1'b0);
		r1         = mk(OP_REPORT, 8'd0, 16'd0, ST_OK, 12'sd0, 1'b1);
		case (action_s1)
			ACT_START: begin
				if (phase_q == PH_IDLE) begin
					kind_d   = kind_s1;
					r0       = mk(OP_START, 8'd0, 16'd0, ST_OK, 12'sd0, 1'b0);
					r1       = mk(OP_WRITE, addr_w, 16'd0, ST_OK, 12'sd0, 1'b1);
					load_cnt = 2'd2;
					phase_d  = PH_ADDR_ACK;
				end
			end
			ACT_ACK: begin
				case (phase_q)
					PH_ADDR_ACK: begin
						if (!acked_s1) begin
							r1.status = ST_ADDR_NACK;
							load_cnt  = 2'd2;
							phase_d   = PH_IDLE;
						end else begin
							r0 = mk(OP_WRITE, kind_q ? cfg.humid_command : cfg.temp_command,
								16'd0, ST_OK, 12'sd0, 1'b1);
							load_cnt = 2'd1;
							phase_d  = PH_CMD_ACK;
						end
					end
					PH_CMD_ACK: begin
						load_cnt = 2'd2;
						if (!acked_s1) begin
							r1.status = ST_CMD_NACK;
							phase_d   = PH_IDLE;
						end else begin
							r1         = mk(OP_WAIT, 8'd0, cfg.wait_micros, ST_OK, 12'sd0, 1'b1);
							attempts_d = cfg.poll_limit - 8'd1;
							phase_d    = PH_DELAY;
						end
					end
					PH_POLL_ACK: begin
						if (acked_s1) begin
							r0       = mk(OP_READ_ACK, 8'd0, 16'd0, ST_OK, 12'sd0, 1'b1);
							load_cnt = 2'd1;
							idx_d    = 2'd0;
							phase_d  = PH_READ;
						end else if (attempts_q == 8'd0) begin
							r1.status = ST_TIMEOUT;
							load_cnt  = 2'd2;
							phase_d   = PH_IDLE;
						end else begin
							r0         = mk(OP_WAIT, 8'd0, cfg.wait_micros, ST_OK, 12'sd0, 1'b1);
							load_cnt   = 2'd1;
							attempts_d = attempts_q - 8'd1;
							phase_d    = PH_DELAY;
						end
					end
					default: ;
				endcase
			end
			ACT_WAIT_DONE: begin
				if (phase_q == PH_DELAY) begin
					r0       = mk(OP_START, 8'd0, 16'd0, ST_OK, 12'sd0, 1'b0);
					r1       = mk(OP_WRITE, addr_r, 16'd0, ST_OK, 12'sd0, 1'b1);
					load_cnt = 2'd2;
					phase_d  = PH_POLL_ACK;
				end
			end
			ACT_READ: begin
				if (phase_q == PH_READ) begin
					case (idx_q)
						2'd0: begin
							conv_ctl.ld_hi = 1'b1;
							r0       = mk(OP_READ_ACK, 8'd0, 16'd0, ST_OK, 12'sd0, 1'b1);
							load_cnt = 2'd1;
							idx_d    = 2'd1;
						end
						2'd1: begin
							conv_ctl.ld_lo = 1'b1;
							r0       = mk(OP_READ_NACK, 8'd0, 16'd0, ST_OK, 12'sd0, 1'b1);
							load_cnt = 2'd1;
							idx_d    = 2'd2;
						end
						default: begin
							if (crc != byte_s1) begin
								r1.status = ST_CRC_ERR;
							end else begin
								r1.value = conv_value;
							end
							load_cnt = 2'd2;
							idx_d    = 2'd0;
							phase_d  = PH_IDLE;
						end
					endcase
				end
			end
			default: ;
		endcase
		if (!proc) begin
			conv_ctl = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			kind_q     <= 1'b0;
			attempts_q <= 8'd0;
			idx_q      <= 2'd0;
			valid_s1   <= 1'b0;
		end else begin
			if (proc) begin
				phase_q    <= phase_d;
				kind_q     <= kind_d;
				attempts_q <= attempts_d;
				idx_q      <= idx_d;
			end
			if (!cmd_stall) begin
				valid_s1 <= cmd_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			action_s1 <= action_t'(action);
			kind_s1   <= kind;
			acked_s1  <= acked;
			byte_s1   <= read_byte;
		end
	end

`ifndef NO_ASSERTIONS
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_READ |-> idx_q != 2'd3) else $error("read byte index invalid");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> valid_s1 && !free) else $error("stall without pending transaction");
	a_report: assert property (@(posedge clk) disable iff (!arst_n)
		proc && phase_q != PH_IDLE && phase_d == PH_IDLE
		|-> load_cnt == 2'd2 && r1.bus_op == OP_REPORT)
		else $error("sequence ended without report");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		proc && phase_q == PH_IDLE |-> phase_d == PH_IDLE || phase_d == PH_ADDR_ACK)
		else $error("bad exit from idle");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/i2c_humidity_temp_readout.sv -----
// Top level of the I2C humidity/temperature sensor readout sequencer.
// Usage: each command transaction (action, kind, acked, read_byte) reports one
// event from a byte-level I2C master: start request, ack status, received byte
// or end of a wait. The block answers with zero, one or two result
// transactions (bus_op, bus_byte, wait_time, status, value, last) telling the
// master what to do next; last marks the final result of a command.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low. Commands that do not fit the current phase give no result.
// A command is registered, then evaluated into the two-entry result buffer
// once that buffer is free; the results are offered from the buffer registers.
// Throughput: one command per cycle when commands give at most one result and
// the result side does not stall; a command that gives two results holds the
// next command back until its second result moves. The drain of the result
// buffer sets this. While the result side stalls, the buffer holds and the
// command register fills, then cmd_stall rises. Reset clears the phase to idle
// and the registers to their default values; the user must write configuration
// over the APB port only while no sequence is in flight; this is not enforced.
`default_nettype none

module i2c_humidity_temp_readout import htr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire logic [1:0]  action,
	input  wire logic        kind,
	input  wire logic        acked,
	input  wire logic [7:0]  read_byte,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [2:0]       bus_op,
	output logic [7:0]       bus_byte,
	output logic [15:0]      wait_time,
	output logic [2:0]       status,
	output logic signed [11:0] value,
	output logic             last
);

	cfg_t               cfg;
	conv_ctl_t          conv_ctl;
	logic [7:0]         conv_data;
	logic               conv_kind;
	logic [7:0]         crc;
	logic signed [11:0] conv_value;
	logic               free;
	logic               load;
	logic [1:0]         load_cnt;
	res_t               r0;
	res_t               r1;
	res_t               res;

	htr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	htr_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.action     (action),
		.kind       (kind),
		.acked      (acked),
		.read_byte  (read_byte),
		.cfg        (cfg),
		.free       (free),
		.crc        (crc),
		.conv_value (conv_value),
		.conv_ctl   (conv_ctl),
		.conv_data  (conv_data),
		.conv_kind  (conv_kind),
		.load       (load),
		.load_cnt   (load_cnt),
		.r0         (r0),
		.r1         (r1)
	);

	htr_conv u_conv (
		.clk   (clk),
		.ctl   (conv_ctl),
		.data  (conv_data),
		.kind  (conv_kind),
		.crc   (crc),
		.value (conv_value)
	);

	htr_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.load_cnt  (load_cnt),
		.r0        (r0),
		.r1        (r1),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res       (res),
		.free      (free)
	);

	assign bus_op    = res.bus_op;
	assign bus_byte  = res.bus_byte;
	assign wait_time = res.wait_time;
	assign status    = res.status;
	assign value     = res.value;
	assign last      = res.last;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the I2C humidity/temperature readout sequencer.
module testbench;
	import htr_pkg::*;

	typedef enum logic [1:0] {
		ACT_START,
		ACT_ACK,
		ACT_BYTE,
		ACT_WAIT_DONE
	} action_t;

	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_ADDR_ACK,
		SEQ_CMD_ACK,
		SEQ_DELAY,
		SEQ_POLL_ACK,
		SEQ_READ
	} seq_phase_t;

	typedef enum int {
		REG_DEVICE_ADDRESS,
		REG_TEMP_COMMAND,
		REG_HUMID_COMMAND,
		REG_POLL_LIMIT,
		REG_WAIT_MICROS,
		REG_UNUSED
	} reg_index_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_BURSTY
	} stall_mode_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	wire  [31:0] prdata;
	wire         pready;
	logic        cmd_valid;
	wire         cmd_stall;
	logic [1:0]  action;
	logic        kind;
	logic        acked;
	logic [7:0]  read_byte;
	wire         res_valid;
	logic        res_stall;
	wire  [2:0]  bus_op;
	wire  [7:0]  bus_byte;
	wire  [15:0] wait_time;
	wire  [2:0]  status;
	wire signed [11:0] value;
	wire         last;

	i2c_humidity_temp_readout dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.action(action), .kind(kind), .acked(acked), .read_byte(read_byte),
		.res_valid(res_valid), .res_stall(res_stall),
		.bus_op(bus_op), .bus_byte(bus_byte), .wait_time(wait_time),
		.status(status), .value(value), .last(last)
	);

	// shadow of the sequencer
	cfg_t       shadow_cfg;
	seq_phase_t seq_phase;
	logic       meas_kind;
	logic [7:0] attempts_left;
	logic [7:0] hi_byte;
	logic [7:0] lo_byte;
	logic [1:0] byte_index;

	res_t expected_bus_ops[$];
	int   mismatch_count = 0;
	int   items_sent = 0;
	int   burst_left = 0;
	bit   gaps_enabled = 1'b1;

	stall_mode_t stall_mode = STALL_NONE;
	int   stall_stretch = 0;
	int   stall_run = 0;
	logic stall_hold = 1'b0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
		int i;
		crc = crc ^ b;
		for (i = 0; i < 8; i++)
			crc = crc[7] ? ((crc << 1) ^ 8'h31) : (crc << 1);
		return crc;
	endfunction

	function automatic logic [7:0] reading_crc(logic [15:0] raw);
		return crc8_step(crc8_step(8'h00, raw[15:8]), raw[7:0]);
	endfunction

	// temperature in tenths truncated toward zero, humidity in whole percent
	function automatic logic signed [11:0] convert_reading(logic [15:0] raw, logic k);
		longint num;
		int     hum;
		if (k) begin
			hum = ((int'(raw) * 125) >>> 16) - 6;
			return 12'(hum);
		end
		num = longint'(raw) * 17572 - longint'(4685) * 65536;
		return 12'(num / 655360);
	endfunction

	function automatic void push_op(bus_op_t op, logic [7:0] b, logic [15:0] wt,
			status_t st, logic signed [11:0] v, logic lst);
		res_t r;
		r.bus_op    = op;
		r.bus_byte  = b;
		r.wait_time = wt;
		r.status    = st;
		r.value     = v;
		r.last      = lst;
		expected_bus_ops.push_back(r);
	endfunction

	function automatic void reset_shadow();
		shadow_cfg.device_address = 7'd64;
		shadow_cfg.temp_command   = 8'd243;
		shadow_cfg.humid_command  = 8'd245;
		shadow_cfg.poll_limit     = 8'd255;
		shadow_cfg.wait_micros    = 16'd1000;
		seq_phase     = SEQ_IDLE;
		meas_kind     = 1'b0;
		attempts_left = 8'd0;
		hi_byte       = 8'd0;
		lo_byte       = 8'd0;
		byte_index    = 2'd0;
	endfunction

	function automatic void apply_register(reg_index_t idx, logic [31:0] data);
		case (idx)
			REG_DEVICE_ADDRESS: shadow_cfg.device_address = data[6:0];
			REG_TEMP_COMMAND:   shadow_cfg.temp_command   = data[7:0];
			REG_HUMID_COMMAND:  shadow_cfg.humid_command  = data[7:0];
			REG_POLL_LIMIT:     shadow_cfg.poll_limit     = data[7:0];
			REG_WAIT_MICROS:    shadow_cfg.wait_micros    = data[15:0];
			default: ;
		endcase
	endfunction

	function automatic void predict_bus_ops(action_t act, logic k, logic ack, logic [7:0] rb);
		logic [7:0]  addr_w;
		logic [15:0] raw;
		addr_w = {shadow_cfg.device_address, 1'b0};
		case (act)
			ACT_START: begin
				if (seq_phase == SEQ_IDLE) begin
					meas_kind = k;
					push_op(OP_START, 8'd0, 16'd0, ST_OK, 12'sd0, 1'b0);
					push_op(OP_WRITE, addr_w, 16'd0, ST_OK, 12'sd0, 1'b1);
					seq_phase = SEQ_ADDR_ACK;
				end
			end
			ACT_ACK: begin
				case (seq_phase)
					SEQ_ADDR_ACK: begin
						if (!ack) begin
							push_op(OP_STOP, 8'd0, 16'd0, ST_OK, 12'sd0, 1'b0);
							push_op(OP_REPORT, 8'd0, 16'd0, ST_ADDR_NACK, 12'sd0, 1'b1);
							seq_phase = SEQ_IDLE;
						end else begin
							push_op(OP_WRITE, meas_kind ? shadow_cfg.humid_command
								: shadow_cfg.temp_command, 16'd0, ST_OK, 12'sd0, 1'b1);
							seq_phase = SEQ_CMD_ACK;
						end
					end
					SEQ_CMD_ACK: begin
						push_op(OP_STOP, 8'd0, 16'd0, ST_OK, 12'sd0, 1'b0);
						if (!ack) begin
							push_op(OP_REPORT, 8'd0, 16'd0, ST_CMD_NACK, 12'sd0, 1'b1);
							seq_phase = SEQ_IDLE;
						end else begin
							attempts_left = shadow_cfg.poll_limit - 8'd1;
							push_op(OP_WAIT, 8'd0, shadow_cfg.wait_micros, ST_OK, 12'sd0, 1'b1);
							seq_phase = SEQ_DELAY;
						end
					end
					SEQ_POLL_ACK: begin
						if (ack) begin
							push_op(OP_READ_ACK, 8'd0, 16'd0, ST_OK, 12'sd0, 1'b1);
							byte_index = 2'd0;
							seq_phase  = SEQ_READ;
						end else if (attempts_left == 8'd0) begin
							push_op(OP_STOP, 8'd0, 16'd0, ST_OK, 12'sd0, 1'b0);
							push_op(OP_REPORT, 8'd0, 16'd0, ST_TIMEOUT, 12'sd0, 1'b1);
							seq_phase = SEQ_IDLE;
						end else begin
							attempts_left = attempts_left - 8'd1;
							push_op(OP_WAIT, 8'd0, shadow_cfg.wait_micros, ST_OK, 12'sd0, 1'b1);
							seq_phase = SEQ_DELAY;
						end
					end
					default: ;
				endcase
			end
			ACT_WAIT_DONE: begin
				if (seq_phase == SEQ_DELAY) begin
					push_op(OP_START, 8'd0, 16'd0, ST_OK, 12'sd0, 1'b0);
					push_op(OP_WRITE, addr_w | 8'd1, 16'd0, ST_OK, 12'sd0, 1'b1);
					seq_phase = SEQ_POLL_ACK;
				end
			end
			default: begin
				if (seq_phase == SEQ_READ) begin
					if (byte_index == 2'd0) begin
						hi_byte    = rb;
						byte_index = 2'd1;
						push_op(OP_READ_ACK, 8'd0, 16'd0, ST_OK, 12'sd0, 1'b1);
					end else if (byte_index == 2'd1) begin
						lo_byte    = rb;
						byte_index = 2'd2;
						push_op(OP_READ_NACK, 8'd0, 16'd0, ST_OK, 12'sd0, 1'b1);
					end else begin
						raw = {hi_byte, lo_byte};
						push_op(OP_STOP, 8'd0, 16'd0, ST_OK, 12'sd0, 1'b0);
						if (reading_crc(raw) != rb)
							push_op(OP_REPORT, 8'd0, 16'd0, ST_CRC_ERR, 12'sd0, 1'b1);
						else
							push_op(OP_REPORT, 8'd0, 16'd0, ST_OK,
								convert_reading(raw, meas_kind), 1'b1);
						byte_index = 2'd0;
						seq_phase  = SEQ_IDLE;
					end
				end
			end
		endcase
	endfunction

	function automatic void report_mismatch(string what);
		if (mismatch_count < 10)
			$display("%0t: %s", $realtime, what);
		mismatch_count++;
	endfunction

	always @(posedge clk) begin
		res_t exp_op;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_bus_ops.size() == 0) begin
				report_mismatch($sformatf("unexpected result op %0d byte %02h wait %0d st %0d val %0d",
					bus_op, bus_byte, wait_time, status, value));
			end else begin
				exp_op = expected_bus_ops.pop_front();
				if (bus_op !== exp_op.bus_op || bus_byte !== exp_op.bus_byte
						|| wait_time !== exp_op.wait_time || status !== exp_op.status
						|| value !== exp_op.value || last !== exp_op.last)
					report_mismatch($sformatf({"exp op %0d byte %02h wait %0d st %0d val %0d last %0d",
						" / got op %0d byte %02h wait %0d st %0d val %0d last %0d"},
						exp_op.bus_op, exp_op.bus_byte, exp_op.wait_time, exp_op.status,
						exp_op.value, exp_op.last,
						bus_op, bus_byte, wait_time, status, value, last));
			end
		end
	end

	// result side back-pressure, switching between random stall patterns
	always @(negedge clk) begin
		if (stall_stretch == 0) begin
			stall_mode    = stall_mode_t'($urandom_range(3));
			stall_stretch = $urandom_range(300, 40);
		end
		stall_stretch--;
		case (stall_mode)
			STALL_NONE:  res_stall <= 1'b0;
			STALL_LIGHT: res_stall <= ($urandom_range(99) < 25);
			STALL_HEAVY: res_stall <= ($urandom_range(99) < 70);
			default: begin
				if (stall_run == 0) begin
					stall_hold = ~stall_hold;
					stall_run  = $urandom_range(9, 1);
				end
				stall_run--;
				res_stall <= stall_hold;
			end
		endcase
	end

	task automatic send_command(action_t act, logic sel_kind, logic ack_bit, logic [7:0] rx_byte);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(12, 1);
			if (gaps_enabled) begin
				gap = $urandom_range(6, 1);
				cmd_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		cmd_valid <= 1'b1;
		action    <= act;
		kind      <= sel_kind;
		acked     <= ack_bit;
		read_byte <= rx_byte;
		do @(posedge clk); while (cmd_stall);
		predict_bus_ops(act, sel_kind, ack_bit, rx_byte);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_for_drain();
		cmd_valid <= 1'b0;
		while (expected_bus_ops.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic apb_write(reg_index_t idx, logic [31:0] data);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= 5'(4 * idx);
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		apply_register(idx, data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// upper bits carry noise; the block keeps only the register width
	task automatic write_all_registers(logic [6:0] addr7, logic [7:0] tcmd, logic [7:0] hcmd,
			logic [7:0] poll, logic [15:0] wt);
		apb_write(REG_DEVICE_ADDRESS, ($urandom & ~32'h7F) | addr7);
		apb_write(REG_TEMP_COMMAND, ($urandom & ~32'hFF) | tcmd);
		apb_write(REG_HUMID_COMMAND, ($urandom & ~32'hFF) | hcmd);
		apb_write(REG_POLL_LIMIT, ($urandom & ~32'hFF) | poll);
		apb_write(REG_WAIT_MICROS, ($urandom & ~32'hFFFF) | wt);
	endtask

	task automatic measure_raw(logic k, logic [15:0] raw, bit crc_good);
		send_command(ACT_START, k, 1'b0, 8'h00);
		send_command(ACT_ACK, 1'b0, 1'b1, 8'h00);
		send_command(ACT_ACK, 1'b0, 1'b1, 8'h00);
		send_command(ACT_WAIT_DONE, 1'b0, 1'b0, 8'h00);
		send_command(ACT_ACK, 1'b0, 1'b1, 8'h00);
		send_command(ACT_BYTE, 1'b0, 1'b0, raw[15:8]);
		send_command(ACT_BYTE, 1'b0, 1'b0, raw[7:0]);
		send_command(ACT_BYTE, 1'b0, 1'b0, crc_good ? reading_crc(raw) : ~reading_crc(raw));
	endtask

	// one measurement, mostly well formed, ending back in idle
	task automatic run_measurement(int poll_ack_pct, int noise_pct);
		logic [7:0] rb;
		send_command(ACT_START, 1'($urandom_range(1)), 1'($urandom_range(1)),
			8'($urandom_range(255)));
		while (seq_phase != SEQ_IDLE) begin
			if ($urandom_range(99) < noise_pct) begin
				send_command(action_t'($urandom_range(3)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 8'($urandom_range(255)));
			end else begin
				case (seq_phase)
					SEQ_ADDR_ACK, SEQ_CMD_ACK:
						send_command(ACT_ACK, 1'($urandom_range(1)), $urandom_range(99) < 92,
							8'($urandom_range(255)));
					SEQ_DELAY:
						send_command(ACT_WAIT_DONE, 1'($urandom_range(1)),
							1'($urandom_range(1)), 8'($urandom_range(255)));
					SEQ_POLL_ACK:
						send_command(ACT_ACK, 1'($urandom_range(1)),
							$urandom_range(99) < poll_ack_pct, 8'($urandom_range(255)));
					default: begin
						case ($urandom_range(4))
							0: rb = 8'h00;
							1: rb = 8'hFF;
							default: rb = 8'($urandom_range(255));
						endcase
						if (byte_index == 2'd2 && $urandom_range(99) < 80)
							rb = reading_crc({hi_byte, lo_byte});
						send_command(ACT_BYTE, 1'($urandom_range(1)), 1'($urandom_range(1)), rb);
					end
				endcase
			end
		end
	endtask

	task automatic test_conversion_extremes();
		measure_raw(1'b0, 16'h0000, 1'b1);
		measure_raw(1'b1, 16'hFFFF, 1'b1);
		wait_for_drain();
	endtask

	task automatic test_failures();
		send_command(ACT_BYTE, 1'b0, 1'b1, 8'h5A);
		send_command(ACT_WAIT_DONE, 1'b1, 1'b1, 8'hA5);
		send_command(ACT_ACK, 1'b0, 1'b1, 8'h00);
		send_command(ACT_START, 1'b0, 1'b0, 8'h00);
		send_command(ACT_ACK, 1'b0, 1'b0, 8'h00);
		send_command(ACT_START, 1'b1, 1'b0, 8'h00);
		send_command(ACT_ACK, 1'b0, 1'b1, 8'h00);
		send_command(ACT_START, 1'b0, 1'b1, 8'h00);
		send_command(ACT_ACK, 1'b0, 1'b0, 8'h00);
		measure_raw(1'b0, 16'h6C3A, 1'b0);
		wait_for_drain();
	endtask

	task automatic test_poll_limits();
		write_all_registers(7'd64, 8'd243, 8'd245, 8'd1, 16'd1000);
		send_command(ACT_START, 1'b0, 1'b0, 8'h00);
		send_command(ACT_ACK, 1'b0, 1'b1, 8'h00);
		send_command(ACT_ACK, 1'b0, 1'b1, 8'h00);
		send_command(ACT_WAIT_DONE, 1'b0, 1'b0, 8'h00);
		send_command(ACT_ACK, 1'b0, 1'b0, 8'h00);
		wait_for_drain();
		// zero limit wraps, so early misses keep polling
		write_all_registers(7'd64, 8'd243, 8'd245, 8'd0, 16'd1000);
		send_command(ACT_START, 1'b1, 1'b0, 8'h00);
		send_command(ACT_ACK, 1'b0, 1'b1, 8'h00);
		send_command(ACT_ACK, 1'b0, 1'b1, 8'h00);
		repeat (4) begin
			send_command(ACT_WAIT_DONE, 1'b0, 1'b1, 8'h00);
			send_command(ACT_ACK, 1'b0, 1'b0, 8'h00);
		end
		send_command(ACT_WAIT_DONE, 1'b0, 1'b0, 8'h00);
		send_command(ACT_ACK, 1'b0, 1'b1, 8'h00);
		send_command(ACT_BYTE, 1'b0, 1'b0, 8'h7B);
		send_command(ACT_BYTE, 1'b0, 1'b0, 8'h2E);
		send_command(ACT_BYTE, 1'b0, 1'b0, reading_crc(16'h7B2E));
		wait_for_drain();
	endtask

	task automatic test_random_traffic();
		int round_no;
		int round_end;
		for (round_no = 0; round_no < 10; round_no++) begin
			wait_for_drain();
			case (round_no)
				0: write_all_registers(7'd0, 8'd0, 8'd0, 8'd1, 16'd0);
				1: write_all_registers(7'd127, 8'd255, 8'd255, 8'd255, 16'd65535);
				default: write_all_registers(7'($urandom_range(127)), 8'($urandom_range(255)),
					8'($urandom_range(255)),
					$urandom_range(1) ? 8'($urandom_range(4, 1)) : 8'($urandom_range(255, 1)),
					16'($urandom_range(65535)));
			endcase
			if (round_no == 4)
				apb_write(REG_UNUSED, $urandom);
			gaps_enabled = (round_no % 3 != 2);
			round_end = items_sent + 45;
			while (items_sent < round_end)
				run_measurement($urandom_range(60, 10), 12);
		end
		gaps_enabled = 1'b1;
		wait_for_drain();
	endtask

	initial begin
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = 5'd0;
		pwdata    = 32'd0;
		cmd_valid = 1'b0;
		action    = ACT_START;
		kind      = 1'b0;
		acked     = 1'b0;
		read_byte = 8'd0;
		res_stall = 1'b0;
		reset_shadow();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_conversion_extremes();
		test_failures();
		test_poll_limits();
		test_random_traffic();

		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && expected_bus_ops.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
